>>> rtl/tpfa_pkg.sv
// Shared types, widths and constants of the tabulated pair force accumulator.
// Depends on nothing; every other file of the block imports it.
package tpfa_pkg;

    localparam int PARTICLE_DEPTH_DEF = 2048;
    localparam int TABLE_DEPTH_DEF    = 65536;
    localparam int PART_W  = 11;
    localparam int POS_W   = 24;
    localparam int TADDR_W = 16;
    localparam int TVAL_W  = 32;
    localparam int FORCE_W = 40;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 96;

    typedef enum logic [1:0] {
        REQ_LOAD_POS = 2'd0,
        REQ_LOAD_TAB = 2'd1,
        REQ_PAIR     = 2'd2,
        REQ_READ     = 2'd3
    } t_req;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BOX_W     = 3'd0,
        CFG_BOX_H     = 3'd1,
        CFG_TAB_START = 3'd2,
        CFG_TAB_INV   = 3'd3,
        CFG_TAB_ENT   = 3'd4
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE, ST_PRD, ST_FOLD, ST_SQ, ST_D2, ST_MLO, ST_MHI, ST_IDX,
        ST_TRD, ST_SCL, ST_FRD_A, ST_WR_A, ST_WR_B, ST_RRD, ST_OUT
    } t_state;

    localparam logic signed [FORCE_W-1:0] ACC_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic signed [FORCE_W-1:0] ACC_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

    // Saturating accumulate
    function automatic logic signed [FORCE_W-1:0] sat_add(
        input logic signed [FORCE_W-1:0] acc,
        input logic signed [FORCE_W:0] delta);
        logic signed [FORCE_W+1:0] s;
        s = {{2{acc[FORCE_W-1]}}, acc} + {delta[FORCE_W], delta};
        if (s > $signed({2'b00, ACC_MAX})) sat_add = ACC_MAX;
        else if (s < $signed({2'b11, ACC_MIN})) sat_add = ACC_MIN;
        else sat_add = s[FORCE_W-1:0];
    endfunction

endpackage

>>> rtl/tpfa_force_mem.sv
// Force accumulator memory (x and y packed in one word) with a synchronous, registered read.
// Depends on tpfa_pkg.
module tpfa_force_mem #(
    parameter int DEPTH = tpfa_pkg::PARTICLE_DEPTH_DEF,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [AW-1:0]                  i_waddr,
    input  logic [2*tpfa_pkg::FORCE_W-1:0] i_wdata,
    input  logic [AW-1:0]                  i_raddr,
    output logic [2*tpfa_pkg::FORCE_W-1:0] o_rdata
);
    import tpfa_pkg::*;

    logic [2*FORCE_W-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

>>> rtl/tabulated_pair_force_accumulator_core.sv
// Tabulated pair force accumulator: one item at a time. A load of a position or table
// word is done as it is taken (clear pass excepted); a pair runs ST_PRD to ST_WR_B, a read
// runs ST_RRD and ST_OUT. The pair steps: two position reads on the position port,
// squared distance and index products each on one shared 32x32 multiplier,
// table read, then read-modify-write of both force entries in one force memory.
// After reset the force store is swept to zero, one entry per cycle, while no item is
// taken. Results wait in an output register that does not block the input; a read
// holds in ST_OUT while the previous result is still waiting there.
// Depends on tpfa_pkg and tpfa_force_mem.
module tabulated_pair_force_accumulator_core #(
    parameter int PARTICLE_DEPTH = tpfa_pkg::PARTICLE_DEPTH_DEF,
    parameter int TABLE_DEPTH    = tpfa_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // req_type[1:0], particle_a[12:2], particle_b[23:13], pos_x[47:24],
    // pos_y[71:48], table_address[87:72], table_value[119:88]
    input  logic [tpfa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // particle_out[10:0], force_x[50:11], force_y[90:51], zero fill
    output logic [tpfa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [tpfa_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [tpfa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tpfa_pkg::*;

    localparam int PAW = $clog2(PARTICLE_DEPTH);
    localparam int TAW = $clog2(TABLE_DEPTH);

    // Configuration
    logic [POS_W-1:0]  r_box_w, r_box_h;
    logic [31:0]       r_tab_start, r_tab_inv;
    logic [16:0]       r_tab_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_w     <= 24'd3932160;
            r_box_h     <= 24'd3932160;
            r_tab_start <= 32'd655;
            r_tab_inv   <= 32'd91052697;
            r_tab_ent   <= 17'd50000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BOX_W:     r_box_w     <= i_cfg_data[POS_W-1:0];
                CFG_BOX_H:     r_box_h     <= i_cfg_data[POS_W-1:0];
                CFG_TAB_START: r_tab_start <= i_cfg_data;
                CFG_TAB_INV:   r_tab_inv   <= i_cfg_data;
                CFG_TAB_ENT:   r_tab_ent   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Input fields
    t_req              in_type;
    logic [PART_W-1:0] in_a, in_b;
    assign in_type = t_req'(s_axis_tdata[1:0]);
    assign in_a    = s_axis_tdata[12:2];
    assign in_b    = s_axis_tdata[23:13];

    // Item registers
    t_state r_st, n_st;
    logic [PART_W-1:0] r_a, r_b;
    logic              r_ok;
    logic [PAW:0]      r_clr;
    logic [2*POS_W-1:0] r_pa;
    logic signed [POS_W:0] r_dx, r_dy;
    logic [63:0]       r_sq;
    logic [33:0]       r_d2hi;
    logic [47:0]       r_mlo;
    logic [63:0]       r_idx;
    logic [TVAL_W-1:0] r_tval;
    logic signed [FORCE_W:0] r_fx, r_fy;
    logic [2*FORCE_W-1:0] r_fa;
    logic              r_ovld;
    logic [OUT_DATA_W-1:0] r_odata;

    // Position memory (x and y packed), synchronous read
    logic [2*POS_W-1:0] pos_mem [PARTICLE_DEPTH];
    logic [2*POS_W-1:0] pos_rd;
    logic [PAW-1:0]     pos_raddr;
    logic               pos_we;

    // Table memory
    logic [TVAL_W-1:0]  tab_mem [TABLE_DEPTH];
    logic [TVAL_W-1:0]  tab_rd;
    logic               tab_we;
    logic [TAW-1:0]     tab_waddr;

    logic               acc;
    logic               out_load;
    assign s_axis_tready = (r_st == ST_IDLE) && (r_clr[PAW] == 1'b1);
    assign acc = s_axis_tvalid && s_axis_tready;
    // Move a read result into the output register once that register is free or is being emptied
    assign out_load = (r_st == ST_OUT) && (!r_ovld || m_axis_tready);

    assign pos_we = acc && in_type == REQ_LOAD_POS
        && {6'd0, in_a} < 17'(PARTICLE_DEPTH);
    assign tab_we = acc && in_type == REQ_LOAD_TAB
        && {5'd0, s_axis_tdata[87:72]} < 21'(TABLE_DEPTH);
    assign tab_waddr = TAW'(s_axis_tdata[87:72]);
    assign pos_raddr = (r_st == ST_IDLE) ? PAW'(in_a) : PAW'(r_b);

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[PAW'(in_a)] <= s_axis_tdata[71:24];
        end
        pos_rd <= pos_mem[pos_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            tab_mem[tab_waddr] <= s_axis_tdata[119:88];
        end
        tab_rd <= tab_mem[TAW'(r_idx)];
    end

    // Force memory
    logic               f_we;
    logic [PAW-1:0]     f_waddr, f_raddr;
    logic [2*FORCE_W-1:0] f_wdata, f_rd;

    tpfa_force_mem #(.DEPTH(PARTICLE_DEPTH), .AW(PAW)) u_force (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rd)
    );

    // Fold arithmetic
    logic signed [POS_W+1:0] dxr, dyr, fxd, fyd;
    function automatic logic signed [POS_W+1:0] fold(
        input logic signed [POS_W+1:0] d, input logic [POS_W-1:0] box);
        logic signed [POS_W+1:0] h, b, t;
        h = $signed({2'b00, box >> 1});
        b = $signed({2'b00, box});
        t = (d > h) ? d - b : d;
        fold = (t < -h) ? t + b : t;
    endfunction
    assign dxr = $signed({2'b00, r_pa[POS_W-1:0]}) - $signed({2'b00, pos_rd[POS_W-1:0]});
    assign dyr = $signed({2'b00, r_pa[2*POS_W-1:POS_W]})
               - $signed({2'b00, pos_rd[2*POS_W-1:POS_W]});
    assign fxd = fold(dxr, r_box_w);
    assign fyd = fold(dyr, r_box_h);

    // Shared multiplier, unsigned 32x32
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [POS_W:0] mag_x, mag_y;
    assign mag_x = r_dx[POS_W] ? (POS_W+1)'(0) - r_dx : r_dx;
    assign mag_y = r_dy[POS_W] ? (POS_W+1)'(0) - r_dy : r_dy;
    logic signed [34:0] diff;
    assign diff = $signed({1'b0, r_d2hi}) - $signed({3'b000, r_tab_start});

    always_comb begin
        unique case (r_st)
            ST_SQ:  begin mul_a = 32'(mag_x); mul_b = 32'(mag_x); end
            ST_D2:  begin mul_a = 32'(mag_y); mul_b = 32'(mag_y); end
            ST_MLO: begin mul_a = {16'd0, diff[15:0]}; mul_b = r_tab_inv; end
            ST_MHI: begin mul_a = {14'd0, diff[33:16]}; mul_b = r_tab_inv; end
            ST_SCL: begin mul_a = 32'(mag_x); mul_b = r_tval; end
            ST_FRD_A: begin mul_a = 32'(mag_y); mul_b = r_tval; end
            default: begin mul_a = 32'd0; mul_b = 32'd0; end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    logic        idx_hit;
    assign idx_hit = (r_idx < 64'(r_tab_ent)) && (r_idx < 64'(TABLE_DEPTH));

    logic signed [FORCE_W:0] sfx, sfy;
    logic signed [FORCE_W-1:0] fa_x, fa_y;
    assign fa_x = f_rd[FORCE_W-1:0];
    assign fa_y = f_rd[2*FORCE_W-1:FORCE_W];

    // Force memory port control
    always_comb begin
        f_we    = 1'b0;
        f_waddr = PAW'(r_a);
        f_wdata = '0;
        f_raddr = PAW'(r_a);
        if (r_clr[PAW] == 1'b0) begin
            f_we    = 1'b1;
            f_waddr = r_clr[PAW-1:0];
        end else if (pos_we) begin
            f_we    = 1'b1;
            f_waddr = PAW'(in_a);
        end else begin
            unique case (r_st)
                ST_IDLE:  f_raddr = PAW'(in_a);
                ST_FRD_A: f_raddr = PAW'(r_a);
                ST_WR_A: begin
                    f_we = r_ok; f_waddr = PAW'(r_a);
                    f_wdata = {sat_add(fa_y, r_fy), sat_add(fa_x, r_fx)};
                    f_raddr = PAW'(r_b);
                end
                ST_WR_B: begin
                    f_we = r_ok; f_waddr = PAW'(r_b);
                    f_wdata = {sat_add(fa_y, -r_fy), sat_add(fa_x, -r_fx)};
                end
                ST_RRD: begin
                    f_we = r_ok; f_waddr = PAW'(r_a);
                end
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (acc && in_type == REQ_PAIR) n_st = ST_PRD;
                     else if (acc && in_type == REQ_READ) n_st = ST_RRD;
            ST_PRD:   n_st = r_ok ? ST_FOLD : ST_IDLE;
            ST_FOLD:  n_st = ST_SQ;
            ST_SQ:    n_st = ST_D2;
            ST_D2:    n_st = ST_MLO;
            ST_MLO:   n_st = ST_MHI;
            ST_MHI:   n_st = ST_IDX;
            ST_IDX:   n_st = ST_TRD;
            ST_TRD:   n_st = ST_SCL;
            ST_SCL:   n_st = ST_FRD_A;
            ST_FRD_A: n_st = ST_WR_A;
            ST_WR_A:  n_st = ST_WR_B;
            ST_WR_B:  n_st = ST_IDLE;
            ST_RRD:   n_st = ST_OUT;
            ST_OUT:   n_st = out_load ? ST_IDLE : ST_OUT;
            default:  n_st = ST_IDLE;
        endcase
    end

    assign sfx = r_dx[POS_W] ? -$signed({1'b0, mul_p[59:20]}) : $signed({1'b0, mul_p[59:20]});
    assign sfy = r_dy[POS_W] ? -$signed({1'b0, mul_p[59:20]}) : $signed({1'b0, mul_p[59:20]});

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_clr  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_clr[PAW] == 1'b0) r_clr <= r_clr + 1'b1;
            if (out_load) r_ovld <= 1'b1;
            else if (m_axis_tready) r_ovld <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a  <= in_a;
            r_b  <= in_b;
            r_ok <= (in_type == REQ_READ) ? ({6'd0, in_a} < 17'(PARTICLE_DEPTH))
                  : ({6'd0, in_a} < 17'(PARTICLE_DEPTH))
                    && ({6'd0, in_b} < 17'(PARTICLE_DEPTH));
        end
        unique case (r_st)
            ST_PRD:  r_pa <= pos_rd;
            ST_FOLD: begin r_dx <= (POS_W+1)'(fxd); r_dy <= (POS_W+1)'(fyd); end
            ST_SQ:   r_sq <= mul_p;
            ST_D2:   r_d2hi <= 34'((r_sq + mul_p) >> 16);
            ST_MLO:  r_mlo <= 48'(mul_p >> 16);
            ST_MHI:  r_idx <= diff[34] || diff == 35'sd0 ? 64'd0
                            : (mul_p + 64'(r_mlo)) >> 16;
            ST_IDX:  if (!idx_hit) r_idx <= 64'(TABLE_DEPTH);
            ST_TRD:  r_tval <= idx_hit ? tab_rd : 32'd0;
            ST_SCL:  r_fx <= sfx;
            ST_FRD_A: r_fy <= sfy;
            ST_RRD:  r_fa <= r_ok ? f_rd : '0;
            default: ;
        endcase
        if (out_load) r_odata <= {5'd0, r_fa, r_a};
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
endmodule

>>> rtl/tpfa_checker.sv
// Port-level checks for the tabulated pair force accumulator, bound to the top.
// Depends on tpfa_pkg.
module tpfa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [tpfa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tpfa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import tpfa_pkg::*;

    // Result word holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed under stall");

    // One item at a time: a read word blocks the input on the next cycle
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == REQ_READ |=> !s_axis_tready)
        else $error("input taken while a read is in flight");

    // Fill bits are zero
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:91] == '0)
        else $error("fill bits set");
endmodule

bind tabulated_pair_force_accumulator_core tpfa_checker u_tpfa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

>>> verif/testbench.sv
// Self-checking bench for tabulated_pair_force_accumulator_core: drives request words
// on the input stream, predicts force reports and compares them on the output stream.
// Depends on tpfa_pkg and the core RTL only.
module testbench;
    import tpfa_pkg::*;

    localparam int  NPART      = PARTICLE_DEPTH_DEF;
    localparam int  NTAB       = TABLE_DEPTH_DEF;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  SETTLE     = 30;
    localparam longint FMAX    = 64'sd549755813887;
    localparam longint FMIN    = -64'sd549755813888;

    typedef struct {
        logic [PART_W-1:0]         particle;
        logic signed [FORCE_W-1:0] fx;
        logic signed [FORCE_W-1:0] fy;
    } t_force_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    tabulated_pair_force_accumulator_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow state of the core
    longint unsigned box_w, box_h, tab_start, tab_inv, tab_ent;
    logic [POS_W-1:0]  shadow_px [NPART];
    logic [POS_W-1:0]  shadow_py [NPART];
    bit                pos_loaded [NPART];
    longint            acc_fx [NPART];
    longint            acc_fy [NPART];
    logic [TVAL_W-1:0] shadow_tab [NTAB];
    bit                tab_loaded [NTAB];
    int                loaded_list [$];

    t_force_report pending_reports [$];
    int  mismatches = 0;
    int  words_sent = 0;
    int  reports_seen = 0;
    int  pairs_sent = 0;
    int  cycles = 0;
    int  burst_left = 0;
    int  hold_off = 0;

    // Minimum-image fold on a periodic box
    function automatic longint fold_delta(longint d, longint unsigned box);
        longint b, half;
        b = longint'(box);
        half = longint'(box >> 1);
        if (d > half) d -= b;
        if (d < -half) d += b;
        return d;
    endfunction

    function automatic longint scale_force(longint unsigned t, longint d);
        longint unsigned mag;
        longint q;
        mag = (d < 0) ? longint'(-d) : d;
        q = longint'((mag * t) >> 20);
        return (d < 0) ? -q : q;
    endfunction

    function automatic longint sat_acc(longint acc, longint delta);
        longint s;
        s = acc + delta;
        if (s > FMAX) return FMAX;
        if (s < FMIN) return FMIN;
        return s;
    endfunction

    function automatic longint pair_dx(int a, int b);
        return fold_delta(longint'(shadow_px[a]) - longint'(shadow_px[b]), box_w);
    endfunction

    function automatic longint pair_dy(int a, int b);
        return fold_delta(longint'(shadow_py[a]) - longint'(shadow_py[b]), box_h);
    endfunction

    // Table entry that a pair looks up
    function automatic longint unsigned pair_index(int a, int b);
        longint dx, dy, diff;
        longint unsigned d2, u;
        dx = pair_dx(a, b);
        dy = pair_dy(a, b);
        d2 = (longint'(dx * dx) + longint'(dy * dy)) >> 16;
        diff = longint'(d2) - longint'(tab_start);
        if (diff <= 0) return 0;
        u = diff;
        return ((u >> 16) * tab_inv + (((u & 64'hFFFF) * tab_inv) >> 16)) >> 16;
    endfunction

    // Advance the shadow state by one accepted word
    task automatic predict_word(t_req req, int a, int b, logic [POS_W-1:0] px,
                                logic [POS_W-1:0] py, int ta, logic [TVAL_W-1:0] tv);
        longint unsigned idx;
        longint fx, fy, dx, dy;
        t_force_report rep;
        case (req)
            REQ_LOAD_POS: begin
                shadow_px[a] = px;
                shadow_py[a] = py;
                acc_fx[a] = 0;
                acc_fy[a] = 0;
                if (!pos_loaded[a]) loaded_list.push_back(a);
                pos_loaded[a] = 1'b1;
            end
            REQ_LOAD_TAB: begin
                shadow_tab[ta] = tv;
                tab_loaded[ta] = 1'b1;
            end
            REQ_PAIR: begin
                fx = 0;
                fy = 0;
                idx = pair_index(a, b);
                if (idx < tab_ent && idx < NTAB) begin
                    dx = pair_dx(a, b);
                    dy = pair_dy(a, b);
                    fx = scale_force(shadow_tab[idx], dx);
                    fy = scale_force(shadow_tab[idx], dy);
                end
                acc_fx[a] = sat_acc(acc_fx[a], fx);
                acc_fy[a] = sat_acc(acc_fy[a], fy);
                acc_fx[b] = sat_acc(acc_fx[b], -fx);
                acc_fy[b] = sat_acc(acc_fy[b], -fy);
            end
            default: begin
                rep.particle = a[PART_W-1:0];
                rep.fx = acc_fx[a][FORCE_W-1:0];
                rep.fy = acc_fy[a][FORCE_W-1:0];
                pending_reports.push_back(rep);
                acc_fx[a] = 0;
                acc_fy[a] = 0;
            end
        endcase
    endtask

    // Offer one word in bursts with random gaps; returns at a falling edge
    task automatic send_word(t_req req, int a, int b, logic [POS_W-1:0] px,
                             logic [POS_W-1:0] py, int ta, logic [TVAL_W-1:0] tv);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tdata = {tv, ta[TADDR_W-1:0], py, px, b[PART_W-1:0], a[PART_W-1:0], req};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_word(req, a, b, px, py, ta, tv);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_table(int ta, logic [TVAL_W-1:0] tv);
        send_word(REQ_LOAD_TAB, 0, 0, '0, '0, ta, tv);
    endtask

    task automatic load_pos(int a, logic [POS_W-1:0] px, logic [POS_W-1:0] py);
        send_word(REQ_LOAD_POS, a, 0, px, py, 0, '0);
    endtask

    task automatic read_force(int a);
        send_word(REQ_READ, a, 0, '0, '0, 0, '0);
    endtask

    // Apply a pair, filling the looked-up table entry first if it is still empty
    task automatic apply_pair(int a, int b);
        longint unsigned idx;
        idx = pair_index(a, b);
        if (idx < tab_ent && idx < NTAB && !tab_loaded[idx])
            load_table(int'(idx), $urandom());
        send_word(REQ_PAIR, a, b, '0, '0, 0, '0);
        pairs_sent++;
    endtask

    // Hold the sender until every report is back and the core has gone quiet
    task automatic drain();
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, longint unsigned val);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        case (idx)
            CFG_BOX_W:     box_w = val & 64'hFFFFFF;
            CFG_BOX_H:     box_h = val & 64'hFFFFFF;
            CFG_TAB_START: tab_start = val & 64'hFFFFFFFF;
            CFG_TAB_INV:   tab_inv = val & 64'hFFFFFFFF;
            default:       tab_ent = val & 64'h1FFFF;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_config(longint unsigned bw, longint unsigned bh, longint unsigned st,
                              longint unsigned inv, longint unsigned ent);
        drain();
        write_reg(CFG_BOX_W, bw);
        write_reg(CFG_BOX_H, bh);
        write_reg(CFG_TAB_START, st);
        write_reg(CFG_TAB_INV, inv);
        write_reg(CFG_TAB_ENT, ent);
    endtask

    // Field extremes, wrap of the box, negative index, same particle, empty read
    task automatic test_directed();
        load_table(0, 32'h0010_0000);
        load_table(NTAB - 1, 32'hFFFF_FFFF);
        load_pos(0, 24'h000000, 24'h000000);
        load_pos(NPART - 1, 24'hFFFFFF, 24'hFFFFFF);
        load_pos(1, 24'h000100, 24'h000080);
        load_pos(2, 24'h3BFF00, 24'h3BFF80);
        apply_pair(0, 0);
        apply_pair(1, 2);
        apply_pair(0, 1);
        apply_pair(0, NPART - 1);
        apply_pair(NPART - 1, 2);
        read_force(0);
        read_force(1);
        read_force(2);
        read_force(NPART - 1);
        read_force(5);
        read_force(0);
    endtask

    // Large table word and full-range displacement until both rails clip
    task automatic test_saturation();
        set_config(0, 0, 0, 0, 65536);
        load_table(0, 32'hFFFF_FFFF);
        load_pos(10, 24'hFFFFFF, 24'h000000);
        load_pos(11, 24'h000000, 24'hFFFFFF);
        repeat (12) apply_pair(10, 11);
        read_force(10);
        read_force(11);
        read_force(10);
    endtask

    // Stall the receiver for a long stretch while words keep coming
    task automatic test_backpressure();
        int k;
        hold_off = 400;
        for (k = 0; k < 40; k++) begin
            if (k % 3 == 0) read_force(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
            else apply_pair(loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                            loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
        end
        drain();
    endtask

    function automatic logic [POS_W-1:0] near_pos(longint unsigned box);
        longint unsigned off;
        off = $urandom_range(0, 16'h1400);
        case ($urandom_range(0, 3))
            0: return off;
            1: return (box - off);
            2: return 24'h200000 + off;
            default: return $urandom();
        endcase
    endfunction

    // Mostly pairs among loaded particles, with loads, table writes and reads mixed in
    task automatic test_random(int count);
        int k, r, a, b;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                a = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 63) : $urandom_range(0, NPART - 1);
                load_pos(a, near_pos(box_w), near_pos(box_h));
            end else if (r < 14) begin
                load_table(($urandom_range(0, 1) != 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(0, NTAB - 1), $urandom());
            end else if (r < 72) begin
                a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                b = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                apply_pair(a, b);
            end else begin
                a = ($urandom_range(0, 9) != 0) ? loaded_list[$urandom_range(0, loaded_list.size() - 1)]
                                                : $urandom_range(0, NPART - 1);
                read_force(a);
            end
        end
    endtask

    // Receiver stall pattern, with an explicit hold-off counter
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case ((cycles / 256) % 3)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare each report with the oldest prediction
    always @(posedge i_clk) begin
        t_force_report exp_rep;
        logic [PART_W-1:0] got_p;
        logic signed [FORCE_W-1:0] got_fx, got_fy;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_p = m_axis_tdata[10:0];
            got_fx = m_axis_tdata[50:11];
            got_fy = m_axis_tdata[90:51];
            reports_seen++;
            if (pending_reports.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected report: particle %0d fx %0d fy %0d", got_p, got_fx, got_fy);
                mismatches++;
            end else begin
                exp_rep = pending_reports.pop_front();
                if (got_p !== exp_rep.particle || got_fx !== exp_rep.fx
                        || got_fy !== exp_rep.fy) begin
                    if (mismatches < 10)
                        $display("report mismatch: expected p %0d fx %0d fy %0d, got p %0d fx %0d fy %0d",
                                 exp_rep.particle, exp_rep.fx, exp_rep.fy, got_p, got_fx, got_fy);
                    mismatches++;
                end
            end
        end
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[tabulated_pair_force_accumulator_core] ERROR");
            $finish;
        end
    end

    initial begin
        box_w = 3932160;
        box_h = 3932160;
        tab_start = 655;
        tab_inv = 91052697;
        tab_ent = 50000;
        for (int i = 0; i < NPART; i++) begin
            acc_fx[i] = 0;
            acc_fy[i] = 0;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_saturation();
        set_config(3932160, 3932160, 655, 91052697, 50000);
        test_backpressure();
        test_random(380);
        set_config(24'hFFFFFF, 24'h0F0000, 0, 32'h0001_0000, 65536);
        test_random(380);
        set_config(24'h010000, 24'h008000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        test_random(360);
        set_config(24'h100000, 24'hFFFFFF, 32'h0000_0100, 32'h0040_0000, 4096);
        test_random(380);
        drain();
        $display("covered %0d words (%0d pairs), %0d force reports checked",
                 words_sent, pairs_sent, reports_seen);
        $display("five register settings incl. zero box, saturation and long output stall");
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("[tabulated_pair_force_accumulator_core] OK");
        else
            $display("[tabulated_pair_force_accumulator_core] ERROR");
        $finish;
    end

endmodule
